FILE: rtl/calendar_date_step_counter_defines.svh
// Assertion macros for the calendar date counter.
`ifndef CALENDAR_DATE_STEP_COUNTER_DEFINES_SVH
`define CALENDAR_DATE_STEP_COUNTER_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define CDSC_ASSERT_NOW(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error(msg);

// Property that must hold in the cycle after its trigger.
`define CDSC_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

FILE: rtl/cdsc_pkg.sv
package cdsc_pkg;

    // Fixed field widths of the request and result payloads.
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int KIND_W  = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Default width of the internal year counter.
    localparam int YEAR_BITS_DEFAULT = 16;

    // The odd part of 400; a year divisible by 100 is divisible by 4 and by this.
    localparam logic [63:0] LEAP_ODD_FACTOR = 64'd25;

    // Month codes with special handling.
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Month lengths.
    localparam logic [DAY_W-1:0] LEN_LONG  = 5'd31;
    localparam logic [DAY_W-1:0] LEN_SHORT = 5'd30;
    localparam logic [DAY_W-1:0] LEN_LEAP  = 5'd29;
    localparam logic [DAY_W-1:0] LEN_FEB   = 5'd28;

    // Command codes; the fourth code is unused and changes nothing.
    typedef enum logic [KIND_W-1:0] {
        CMD_NEXT = 2'd0,
        CMD_PREV = 2'd1,
        CMD_SET  = 2'd2
    } cmd_kind_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEFAULT_ENABLE = 2'd0,
        CFG_DEFAULT_DAY    = 2'd1,
        CFG_DEFAULT_MONTH  = 2'd2,
        CFG_DEFAULT_YEAR   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DAY_W-1:0]   new_day;
        logic [MONTH_W-1:0] new_month;
        logic [YEAR_W-1:0]  new_year;
    } cmd_t;

    typedef struct packed {
        logic [DAY_W-1:0]   cur_day;
        logic [MONTH_W-1:0] cur_month;
        logic [YEAR_W-1:0]  cur_year;
        logic               bad_date;
    } res_t;

    // Inverse of an odd constant modulo 2^bits, by Newton iteration.
    // Each step doubles the number of correct low bits, starting from three.
    function automatic logic [63:0] odd_inverse(input logic [63:0] odd_value, input int bits);
        logic [63:0] x;
        logic [63:0] mask;
        x = odd_value;
        mask = (64'd1 << bits) - 64'd1;
        for (int i = 0; i < 5; i++)
        begin
            x = x * (64'd2 - odd_value * x);
        end
        return x & mask;
    endfunction

endpackage

FILE: rtl/calendar_date_step_counter.sv
// Channel  Direction  Handshake               Payload
// cmd      in         cmd_valid / cmd_ready   cdsc_pkg::cmd_t (kind, new_day, new_month, new_year)
// res      out        res_valid / res_ready   cdsc_pkg::res_t (cur_day, cur_month, cur_year, bad_date)
// cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each request gives one result: an input register holds the prepared request, and the date
// step and result register follow it. A new request is accepted every cycle while results
// are taken; one multiplier for the leap test sits in each of the two register stages.
// Reset gives 1 Jan of year 0, defaults disabled, default date 1 Jan of year 0.
// A stalled result holds both stages; the input register still takes a request while only
// the result register is full. Configuration writes are always accepted.
`include "calendar_date_step_counter_defines.svh"

module calendar_date_step_counter #(
    parameter int YEAR_BITS = cdsc_pkg::YEAR_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  cdsc_pkg::cmd_t                      cmd,
    output logic                                res_valid,
    input  logic                                res_ready,
    output cdsc_pkg::res_t                      res,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cdsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cdsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DAY_W   = cdsc_pkg::DAY_W;
    localparam int MONTH_W = cdsc_pkg::MONTH_W;
    localparam int YEAR_W  = cdsc_pkg::YEAR_W;

    // Constants for the divisibility test by the odd factor of 400.
    localparam logic [63:0] YEAR_MAX64 = (64'd1 << YEAR_BITS) - 64'd1;
    localparam logic [YEAR_BITS-1:0] INV_ODD =
        YEAR_BITS'(cdsc_pkg::odd_inverse(cdsc_pkg::LEAP_ODD_FACTOR, YEAR_BITS));
    localparam logic [YEAR_BITS-1:0] ODD_MULT_MAX =
        YEAR_BITS'(YEAR_MAX64 / cdsc_pkg::LEAP_ODD_FACTOR);

    // Prepared request held in the input register.
    typedef struct packed {
        logic [cdsc_pkg::KIND_W-1:0] kind;
        logic [DAY_W-1:0]            day;
        logic [MONTH_W-1:0]          month;
        logic [YEAR_BITS-1:0]        year;
        logic                        set_ok;
    } stage_t;

    // A year is divisible by 25 exactly when its product with the inverse of 25 stays
    // at or below the largest multiple count. Leap: by 4, and by 16 when also by 25.
    function automatic logic is_leap(input logic [YEAR_BITS-1:0] y);
        logic [YEAR_BITS-1:0] prod;
        logic                 by_odd;
        prod = y * INV_ODD;
        by_odd = (prod <= ODD_MULT_MAX);
        return (y[1:0] == 2'd0) && (!by_odd || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = cdsc_pkg::LEN_LONG;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = cdsc_pkg::LEN_SHORT;
            cdsc_pkg::MONTH_FEB: len = leap ? cdsc_pkg::LEN_LEAP : cdsc_pkg::LEN_FEB;
            default:                                    len = '0;
        endcase
        return len;
    endfunction

    logic                  default_enable_reg;
    logic [DAY_W-1:0]      default_day_reg;
    logic [MONTH_W-1:0]    default_month_reg;
    logic [YEAR_W-1:0]     default_year_reg;

    logic                  s1_valid_reg;
    stage_t                s1_reg;
    stage_t                s1_next;
    logic                  out_valid_reg;
    cdsc_pkg::res_t        out_reg;
    cdsc_pkg::res_t        out_next;

    logic [DAY_W-1:0]      day_reg;
    logic [DAY_W-1:0]      day_next;
    logic [MONTH_W-1:0]    month_reg;
    logic [MONTH_W-1:0]    month_next;
    logic [YEAR_BITS-1:0]  year_reg;
    logic [YEAR_BITS-1:0]  year_next;
    logic                  bad_next;

    logic                  advance;
    logic                  load_out;
    logic                  accept_cmd;

    logic [DAY_W-1:0]      set_day;
    logic [MONTH_W-1:0]    set_month;
    logic [YEAR_W-1:0]     set_year_raw;
    logic [YEAR_BITS-1:0]  set_year;
    logic                  cur_leap;
    logic [DAY_W-1:0]      cur_len;
    logic [MONTH_W-1:0]    prev_month;

    // Handshake: the result register frees when empty or taken; the input register
    // frees when empty or moving on.
    assign advance    = !out_valid_reg || res_ready;
    assign load_out   = s1_valid_reg && advance;
    assign cmd_ready  = !s1_valid_reg || advance;
    assign accept_cmd = cmd_valid && cmd_ready;
    assign cfg_ready  = 1'b1;
    assign res_valid  = out_valid_reg;
    assign res        = out_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_enable_reg <= 1'b0;
            default_day_reg    <= 5'd1;
            default_month_reg  <= 4'd1;
            default_year_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cdsc_pkg::CFG_DEFAULT_ENABLE: default_enable_reg <= cfg_data[0];
                cdsc_pkg::CFG_DEFAULT_DAY:    default_day_reg    <= cfg_data[DAY_W-1:0];
                cdsc_pkg::CFG_DEFAULT_MONTH:  default_month_reg  <= cfg_data[MONTH_W-1:0];
                cdsc_pkg::CFG_DEFAULT_YEAR:   default_year_reg   <= cfg_data[YEAR_W-1:0];
                default: ;
            endcase
        end
    end

    // Request preparation: default substitution and validation of a set date.
    always_comb
    begin
        set_day      = cmd.new_day;
        set_month    = cmd.new_month;
        set_year_raw = cmd.new_year;
        if (default_enable_reg)
        begin
            if (cmd.new_day == '0)
            begin
                set_day = default_day_reg;
            end
            if (cmd.new_month == '0)
            begin
                set_month = default_month_reg;
            end
            if (cmd.new_year == '0)
            begin
                set_year_raw = default_year_reg;
            end
        end
        set_year = YEAR_BITS'(set_year_raw);

        s1_next.kind   = cmd.kind;
        s1_next.day    = set_day;
        s1_next.month  = set_month;
        s1_next.year   = set_year;
        s1_next.set_ok = (set_month >= cdsc_pkg::MONTH_JAN)
                      && (set_month <= cdsc_pkg::MONTH_DEC)
                      && (set_day != '0)
                      && (set_day <= month_len(set_month, is_leap(set_year)));
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            s1_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_cmd)
        begin
            s1_reg <= s1_next;
        end
    end

    // Date step for the request in the input register.
    always_comb
    begin
        cur_leap   = is_leap(year_reg);
        cur_len    = month_len(month_reg, cur_leap);
        prev_month = (month_reg <= cdsc_pkg::MONTH_JAN) ? cdsc_pkg::MONTH_DEC
                                                        : month_reg - 4'd1;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        bad_next   = 1'b0;
        case (s1_reg.kind)
            cdsc_pkg::CMD_NEXT:
            begin
                if (day_reg >= cur_len)
                begin
                    day_next = 5'd1;
                    if (month_reg >= cdsc_pkg::MONTH_DEC)
                    begin
                        month_next = cdsc_pkg::MONTH_JAN;
                        year_next  = year_reg + YEAR_BITS'(1);
                    end
                    else
                    begin
                        month_next = month_reg + 4'd1;
                    end
                end
                else
                begin
                    day_next = day_reg + 5'd1;
                end
            end
            cdsc_pkg::CMD_PREV:
            begin
                if (day_reg <= 5'd1)
                begin
                    month_next = prev_month;
                    if (month_reg <= cdsc_pkg::MONTH_JAN)
                    begin
                        year_next = year_reg - YEAR_BITS'(1);
                    end
                    // Only February depends on the year, and it is never reached
                    // across a year boundary.
                    day_next = month_len(prev_month, cur_leap);
                end
                else
                begin
                    day_next = day_reg - 5'd1;
                end
            end
            cdsc_pkg::CMD_SET:
            begin
                if (s1_reg.set_ok)
                begin
                    day_next   = s1_reg.day;
                    month_next = s1_reg.month;
                    year_next  = s1_reg.year;
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
            default: ;
        endcase

        out_next.cur_day   = day_next;
        out_next.cur_month = month_next;
        out_next.cur_year  = YEAR_W'(year_next);
        out_next.bad_date  = bad_next;
    end

    // Date state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg       <= 5'd1;
            month_reg     <= cdsc_pkg::MONTH_JAN;
            year_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (load_out)
            begin
                day_reg   <= day_next;
                month_reg <= month_next;
                year_reg  <= year_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

    // Checks.
    `CDSC_ASSERT_NOW(a_month_range, out_valid_reg,
        (out_reg.cur_month >= cdsc_pkg::MONTH_JAN) && (out_reg.cur_month <= cdsc_pkg::MONTH_DEC),
        "result month outside 1 to 12")
    `CDSC_ASSERT_NOW(a_day_nonzero, out_valid_reg, out_reg.cur_day != '0,
        "result day is zero")
    `CDSC_ASSERT_NEXT(a_bad_only_on_set, load_out && (s1_reg.kind != cdsc_pkg::CMD_SET),
        !out_reg.bad_date, "bad date flagged on a step command")
    `CDSC_ASSERT_NEXT(a_state_holds_on_stall, out_valid_reg && !res_ready,
        $stable(day_reg) && $stable(month_reg) && $stable(year_reg),
        "date state changed while the result was stalled")

endmodule

FILE: dv/calendar_date_step_counter_tb.sv
`timescale 1ns / 100ps

module calendar_date_step_counter_tb;

    localparam int KIND_W      = cdsc_pkg::KIND_W;
    localparam int DAY_W       = cdsc_pkg::DAY_W;
    localparam int MONTH_W     = cdsc_pkg::MONTH_W;
    localparam int YEAR_W      = cdsc_pkg::YEAR_W;
    localparam int CFG_INDEX_W = cdsc_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = cdsc_pkg::CFG_DATA_W;

    // The fourth command code is unused and must leave the date alone.
    localparam logic [KIND_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS = 2000;
    localparam int PHASES          = 4;
    localparam int IDLE_PERCENT    = 11;
    localparam int MAX_REPORTS     = 40;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cmd_valid = 1'b0;
    logic                   cmd_ready;
    cdsc_pkg::cmd_t         cmd = '0;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    cdsc_pkg::res_t         res;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Local copy of the date and of the default registers.
    logic [DAY_W-1:0]   cal_day = 5'd1;
    logic [MONTH_W-1:0] cal_month = 4'd1;
    logic [YEAR_W-1:0]  cal_year = '0;
    logic               dflt_enable = 1'b0;
    logic [DAY_W-1:0]   dflt_day = 5'd1;
    logic [MONTH_W-1:0] dflt_month = 4'd1;
    logic [YEAR_W-1:0]  dflt_year = '0;

    cdsc_pkg::res_t pending_dates[$];
    cdsc_pkg::res_t next_expected;
    int   mismatch_count = 0;
    int   accepted_count = 0;
    logic quiet_mode = 1'b0;

    calendar_date_step_counter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Safety net in case the block hangs.
    initial
    begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

    // Month length with the 400/4/100 leap rule; zero for a month outside 1 to 12.
    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                       input logic [YEAR_W-1:0] y);
        logic leap;
        leap = (y % 16'd400 == 16'd0) || ((y % 16'd4 == 16'd0) && (y % 16'd100 != 16'd0));
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return cdsc_pkg::LEN_LONG;
            4'd4, 4'd6, 4'd9, 4'd11:                    return cdsc_pkg::LEN_SHORT;
            cdsc_pkg::MONTH_FEB: return leap ? cdsc_pkg::LEN_LEAP : cdsc_pkg::LEN_FEB;
            default:                                    return '0;
        endcase
    endfunction

    // Apply one request to the local date and produce the result it should give.
    task automatic advance_date(input cdsc_pkg::cmd_t c, output cdsc_pkg::res_t r);
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
        logic               bad;
        bad = 1'b0;
        case (c.kind)
            cdsc_pkg::CMD_NEXT:
            begin
                if (6'(cal_day) + 6'd1 > 6'(days_in_month(cal_month, cal_year)))
                begin
                    cal_day = 5'd1;
                    if (cal_month >= cdsc_pkg::MONTH_DEC)
                    begin
                        cal_month = cdsc_pkg::MONTH_JAN;
                        cal_year = cal_year + 16'd1;
                    end
                    else
                    begin
                        cal_month = cal_month + 4'd1;
                    end
                end
                else
                begin
                    cal_day = cal_day + 5'd1;
                end
            end
            cdsc_pkg::CMD_PREV:
            begin
                if (cal_day <= 5'd1)
                begin
                    if (cal_month <= cdsc_pkg::MONTH_JAN)
                    begin
                        cal_month = cdsc_pkg::MONTH_DEC;
                        cal_year = cal_year - 16'd1;
                    end
                    else
                    begin
                        cal_month = cal_month - 4'd1;
                    end
                    cal_day = days_in_month(cal_month, cal_year);
                end
                else
                begin
                    cal_day = cal_day - 5'd1;
                end
            end
            cdsc_pkg::CMD_SET:
            begin
                d = c.new_day;
                m = c.new_month;
                y = c.new_year;
                if (dflt_enable)
                begin
                    if (d == '0) d = dflt_day;
                    if (m == '0) m = dflt_month;
                    if (y == '0) y = dflt_year;
                end
                if (m >= cdsc_pkg::MONTH_JAN && m <= cdsc_pkg::MONTH_DEC && d != '0
                    && d <= days_in_month(m, y))
                begin
                    cal_day = d;
                    cal_month = m;
                    cal_year = y;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.cur_day = cal_day;
        r.cur_month = cal_month;
        r.cur_year = cal_year;
        r.bad_date = bad;
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // The result side stalls at random, except during a quiet stretch.
    always @(posedge clk)
    begin
        res_ready <= quiet_mode || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Compare each accepted result with the oldest outstanding date.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_dates.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
            end
            else
            begin
                next_expected = pending_dates.pop_front();
                if (res.cur_day !== next_expected.cur_day)
                    report_mismatch($sformatf("cur_day %0d, expected %0d",
                                              res.cur_day, next_expected.cur_day));
                if (res.cur_month !== next_expected.cur_month)
                    report_mismatch($sformatf("cur_month %0d, expected %0d",
                                              res.cur_month, next_expected.cur_month));
                if (res.cur_year !== next_expected.cur_year)
                    report_mismatch($sformatf("cur_year %0d, expected %0d",
                                              res.cur_year, next_expected.cur_year));
                if (res.bad_date !== next_expected.bad_date)
                    report_mismatch($sformatf("bad_date %0b, expected %0b",
                                              res.bad_date, next_expected.bad_date));
            end
        end
    end

    // Offer one request, with a random gap first, and record its expected result.
    task automatic send_request(input cdsc_pkg::cmd_t c);
        cdsc_pkg::res_t r;
        while (!quiet_mode && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        advance_date(c, r);
        pending_dates.push_back(r);
        accepted_count++;
    endtask

    task automatic set_date(input int d, input int m, input int y);
        cdsc_pkg::cmd_t c;
        c = '0;
        c.kind = cdsc_pkg::CMD_SET;
        c.new_day = DAY_W'(d);
        c.new_month = MONTH_W'(m);
        c.new_year = YEAR_W'(y);
        send_request(c);
    endtask

    task automatic step_date(input logic [KIND_W-1:0] k);
        cdsc_pkg::cmd_t c;
        c = '0;
        c.kind = k;
        send_request(c);
    endtask

    // Stop sending and wait until every outstanding result has come back.
    task automatic drain_results;
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_dates.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_config(input cdsc_pkg::cfg_index_t idx,
                                input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            cdsc_pkg::CFG_DEFAULT_ENABLE: dflt_enable = value[0];
            cdsc_pkg::CFG_DEFAULT_DAY:    dflt_day = value[DAY_W-1:0];
            cdsc_pkg::CFG_DEFAULT_MONTH:  dflt_month = value[MONTH_W-1:0];
            cdsc_pkg::CFG_DEFAULT_YEAR:   dflt_year = value[YEAR_W-1:0];
            default:
            begin
            end
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_defaults(input logic en, input int d, input int m, input int y);
        drain_results();
        write_config(cdsc_pkg::CFG_DEFAULT_ENABLE, CFG_DATA_W'(en));
        write_config(cdsc_pkg::CFG_DEFAULT_DAY, CFG_DATA_W'(d));
        write_config(cdsc_pkg::CFG_DEFAULT_MONTH, CFG_DATA_W'(m));
        write_config(cdsc_pkg::CFG_DEFAULT_YEAR, CFG_DATA_W'(y));
    endtask

    // Set request aimed at month ends, leap years and the year limits.
    function automatic cdsc_pkg::cmd_t random_set_request();
        cdsc_pkg::cmd_t c;
        int   d;
        int   m;
        int   y;
        int   len;
        c = '0;
        c.kind = cdsc_pkg::CMD_SET;
        case ($urandom_range(0, 4))
            0: y = $urandom_range(0, 65535);
            1: y = 400 * $urandom_range(0, 163);
            2: y = 100 * $urandom_range(0, 655);
            3: y = 4 * $urandom_range(0, 16383);
            default: y = $urandom_range(0, 1) ? 65535 : 0;
        endcase
        m = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 15) : $urandom_range(1, 12);
        len = days_in_month(MONTH_W'(m), YEAR_W'(y));
        case ($urandom_range(0, 3))
            0: d = 1;
            1: d = len;
            2: d = len + 1;
            default: d = $urandom_range(1, 31);
        endcase
        if (d > 31)
            d = 31;
        // Zero fields exercise the default substitution.
        if ($urandom_range(0, 9) == 0) d = 0;
        if ($urandom_range(0, 9) == 0) m = 0;
        if ($urandom_range(0, 9) == 0) y = 0;
        c.new_day = DAY_W'(d);
        c.new_month = MONTH_W'(m);
        c.new_year = YEAR_W'(y);
        return c;
    endfunction

    // Right after reset the date must be 1 Jan of year 0.
    task automatic test_reset_state;
        step_date(CMD_UNUSED);
    endtask

    // Month, year and leap boundaries with defaults disabled.
    task automatic test_calendar_edges;
        set_date(31, 12, 65535);
        step_date(cdsc_pkg::CMD_NEXT);
        step_date(cdsc_pkg::CMD_PREV);
        set_date(28, 2, 1900);
        step_date(cdsc_pkg::CMD_NEXT);
        set_date(29, 2, 1900);
        set_date(29, 2, 2000);
        step_date(cdsc_pkg::CMD_NEXT);
        step_date(cdsc_pkg::CMD_PREV);
        set_date(29, 2, 0);
        set_date(31, 4, 2023);
        set_date(30, 4, 2023);
        step_date(cdsc_pkg::CMD_NEXT);
        set_date(15, 13, 2023);
        set_date(15, 15, 2023);
        set_date(0, 6, 2023);
        set_date(1, 0, 2023);
        set_date(31, 1, 0);
        step_date(CMD_UNUSED);
    endtask

    // Zero fields of a set take the defaults, including defaults that are out of range.
    task automatic test_default_fields;
        load_defaults(1'b1, 31, 12, 65535);
        set_date(0, 0, 0);
        step_date(cdsc_pkg::CMD_NEXT);
        set_date(0, 2, 2001);
        set_date(10, 3, 0);
        drain_results();
        write_config(cdsc_pkg::CFG_DEFAULT_MONTH, 16'd13);
        set_date(5, 0, 2001);
        drain_results();
        write_config(cdsc_pkg::CFG_DEFAULT_DAY, 16'd0);
        set_date(0, 3, 2001);
        load_defaults(1'b0, 1, 1, 0);
        set_date(0, 0, 0);
        set_date(1, 1, 0);
    endtask

    // Mostly a set followed by a run of day steps, with some raw noise in between.
    task automatic test_random_traffic;
        cdsc_pkg::cmd_t    c;
        int                target;
        int                run;
        logic              mixed;
        logic              held_off;
        logic [KIND_W-1:0] dir;
        held_off = 1'b0;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: load_defaults(1'b0, $urandom_range(1, 31), $urandom_range(1, 12),
                                 $urandom_range(0, 65535));
                1: load_defaults(1'b1, 1, 1, 0);
                2: load_defaults(1'b1, 31, 12, 65535);
                default: load_defaults(1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                                       $urandom_range(0, 65535), $urandom_range(0, 65535));
            endcase
            target = accepted_count + RANDOM_REQUESTS / PHASES;
            // A stretch with no idling on either side.
            quiet_mode = (p == 1);
            while (accepted_count < target)
            begin
                if (p == 1 && accepted_count >= target - RANDOM_REQUESTS / (2 * PHASES))
                    quiet_mode = 1'b0;
                // Once the sender holds off until the block has returned everything.
                if (p == 2 && !held_off
                    && accepted_count >= target - RANDOM_REQUESTS / (2 * PHASES))
                begin
                    drain_results();
                    held_off = 1'b1;
                end
                if ($urandom_range(0, 99) < 70)
                begin
                    send_request(random_set_request());
                    run = $urandom_range(1, 40);
                    mixed = ($urandom_range(0, 3) == 0);
                    dir = $urandom_range(0, 1) ? cdsc_pkg::CMD_NEXT : cdsc_pkg::CMD_PREV;
                    for (int i = 0; i < run; i++)
                    begin
                        if (mixed)
                            step_date($urandom_range(0, 1) ? cdsc_pkg::CMD_NEXT
                                                           : cdsc_pkg::CMD_PREV);
                        else
                            step_date(dir);
                    end
                end
                else
                begin
                    c = $bits(cdsc_pkg::cmd_t)'($urandom());
                    send_request(c);
                end
            end
        end
        quiet_mode = 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_calendar_edges();
        test_default_fields();
        test_random_traffic();
        drain_results();
        repeat (2) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
